>>> hdl/ippi_pkg.sv
// Shared constants, types and the arctangent table of the in-plane impulse planner.
package ippi_pkg;

  localparam int FRACTION_BITS = 40;
  localparam int ROOT_STEPS    = 32;
  localparam int CORDIC_STEPS  = 31;
  // magnitude stage, three normalize stages, pre-rotation, then one stage per step
  localparam int CORDIC_LAT    = CORDIC_STEPS + 5;

  localparam logic [23:0] SPEED_RESET = 24'd7585000;

  typedef logic signed [34:0] angle_t;

  localparam angle_t PI_Q30 = 35'sd3373259426;
  localparam logic signed [35:0] PHASE_LIMIT = 36'sd1686629713;

  typedef struct packed {
    logic        radicand_negative;
    logic [31:0] burn_phase;
    logic [31:0] dv_tangential_um_s;
    logic [30:0] dv_radial_um_s;
  } result_t;

  // atan(2^-i) in units of 2^-30 rad
  function automatic angle_t atan_q30(input int i);
    logic [31:0] v;
    begin
      unique case (i)
        0:  v = 32'h3243F6A8;
        1:  v = 32'h1DAC6705;
        2:  v = 32'h0FADBAFC;
        3:  v = 32'h07F56EA6;
        4:  v = 32'h03FEAB76;
        5:  v = 32'h01FFD55B;
        6:  v = 32'h00FFFAAA;
        7:  v = 32'h007FFF55;
        8:  v = 32'h003FFFEA;
        9:  v = 32'h001FFFFD;
        10: v = 32'h000FFFFF;
        11: v = 32'h0007FFFF;
        12: v = 32'h0003FFFF;
        13: v = 32'h0001FFFF;
        14: v = 32'h0000FFFF;
        15: v = 32'h00007FFF;
        16: v = 32'h00003FFF;
        17: v = 32'h00001FFF;
        18: v = 32'h00000FFF;
        19: v = 32'h000007FF;
        20: v = 32'h000003FF;
        21: v = 32'h000001FF;
        22: v = 32'h000000FF;
        23: v = 32'h0000007F;
        24: v = 32'h0000003F;
        25: v = 32'h0000001F;
        26: v = 32'h0000000F;
        27: v = 32'h00000008;
        28: v = 32'h00000004;
        29: v = 32'h00000002;
        30: v = 32'h00000001;
        default: v = 32'h00000000;
      endcase
      atan_q30 = $signed({3'b000, v});
    end
  endfunction

endpackage

>>> hdl/ippi_cordic.sv
// Pipelined vectoring CORDIC: atan2(y, x) with input normalization, LSB 2^-30 rad.
module ippi_cordic (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [33:0]    y_in,
  input  logic signed [33:0]    x_in,
  output ippi_pkg::angle_t      z_out
);
  import ippi_pkg::*;

  logic [33:0] mx, my, mmax;

  logic signed [63:0] nx [0:3];
  logic signed [63:0] ny [0:3];
  logic [63:0]        nm [0:3];
  logic               nz [0:3];

  logic signed [63:0] cx [0:CORDIC_STEPS];
  logic signed [63:0] cy [0:CORDIC_STEPS];
  angle_t             cz [0:CORDIC_STEPS];
  logic               cf [0:CORDIC_STEPS];

  always_comb begin
    mx = x_in[33] ? 34'(-x_in) : 34'(x_in);
    my = y_in[33] ? 34'(-y_in) : 34'(y_in);
    mmax = (mx > my) ? mx : my;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx[0] <= 64'(x_in);
      ny[0] <= 64'(y_in);
      nm[0] <= {30'd0, mmax};
      nz[0] <= (mmax == 34'd0);
    end
  end

  // shift left until the larger magnitude has its top one at bit 59
  genvar j;
  for (j = 0; j < 3; j++) begin : g_norm
    localparam int KA = 32 >> (2 * j);
    localparam int KB = 16 >> (2 * j);
    logic signed [63:0] ax, ay, bx, by;
    logic [63:0]        am, bm;

    always_comb begin
      if (nm[j] < (64'd1 << (60 - KA))) begin
        ax = nx[j] <<< KA;
        ay = ny[j] <<< KA;
        am = nm[j] << KA;
      end else begin
        ax = nx[j];
        ay = ny[j];
        am = nm[j];
      end
      if (am < (64'd1 << (60 - KB))) begin
        bx = ax <<< KB;
        by = ay <<< KB;
        bm = am << KB;
      end else begin
        bx = ax;
        by = ay;
        bm = am;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nx[j+1] <= bx;
        ny[j+1] <= by;
        nm[j+1] <= bm;
        nz[j+1] <= nz[j];
      end
    end
  end

  // pre-rotate by +-pi into the right half plane
  always_ff @(posedge clk) begin
    if (en) begin
      if (nx[3] < 0) begin
        cx[0] <= -nx[3];
        cy[0] <= -ny[3];
        cz[0] <= (ny[3] >= 0) ? PI_Q30 : -PI_Q30;
      end else begin
        cx[0] <= nx[3];
        cy[0] <= ny[3];
        cz[0] <= '0;
      end
      cf[0] <= nz[3];
    end
  end

  genvar i;
  for (i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [63:0] dx, dy;
    assign dx = cy[i] >>> i;
    assign dy = cx[i] >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        if (cy[i] >= 0) begin
          cx[i+1] <= cx[i] + dx;
          cy[i+1] <= cy[i] - dy;
          cz[i+1] <= cz[i] + atan_q30(i);
        end else begin
          cx[i+1] <= cx[i] - dx;
          cy[i+1] <= cy[i] + dy;
          cz[i+1] <= cz[i] - atan_q30(i);
        end
        cf[i+1] <= cf[i];
      end
    end
  end

  // a zero vector gives angle zero
  assign z_out = cf[CORDIC_STEPS] ? '0 : cz[CORDIC_STEPS];

endmodule

>>> hdl/in_plane_impulse_planner_top.sv
// In-plane single-impulse planner: root, two arctangents and speed scaling, fully pipelined.
//
// Input stream (s_*): one item holds delta_semi_major, delta_ecc_x and
// delta_ecc_y. Output stream (m_*): one result item per input item, in
// order, with the radial and tangential velocity change, the burn phase
// and the negative-radicand flag in m_tuser.
// Configuration: cfg_wr_en / cfg_wr_data load the orbit speed (mm/s);
// write it only while no item is in flight.
// Stages from input acceptance to m_tvalid, in order: input, squares and
// radicand, root recurrence, root rounding, CORDIC, product and rounding,
// output register. Throughput: one item per cycle while s_tready is high;
// every stage is a register stage and the 32-step square root and 31-step
// CORDIC each spend one stage per step.
// Reset: clears all valid bits and the output stage and loads the orbit
// speed with 7585000 mm/s.
// Stall: when m_tready is low the result waits in the output register and
// one more item is caught in a skid register; only then does s_tready
// drop and the whole pipeline hold, with nothing lost or repeated.
module in_plane_impulse_planner_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [23:0] cfg_wr_data,     // orbit_speed_mm_s
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,         // delta_semi_major, delta_ecc_x, delta_ecc_y
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,         // dv_radial_um_s(31), dv_tangential_um_s, burn_phase, pad
  output logic        m_tuser          // radicand_negative
);
  import ippi_pkg::*;

  localparam int DEPTH = 4 + ROOT_STEPS + 1 + CORDIC_LAT + 3;
  localparam int SIDE  = CORDIC_LAT;

  logic [23:0] orbit_speed;
  logic [33:0] speed_um;
  logic        en;
  logic [DEPTH-1:0] vld;

  logic signed [31:0] r1_da, r1_ex, r1_ey;
  logic [31:0]        ma, mx, my;
  logic [63:0]        pa, px, py;
  logic [63:0]        r2_sqa, r2_sqx, r2_sqy;
  logic signed [31:0] r2_da, r2_ex, r2_ey;
  logic [63:0]        r3_sum, r3_sqa;
  logic signed [31:0] r3_da, r3_ex, r3_ey;

  logic [63:0]        rt_n   [0:ROOT_STEPS];
  logic [63:0]        rt_res [0:ROOT_STEPS];
  logic signed [31:0] rt_da  [0:ROOT_STEPS];
  logic signed [31:0] rt_ex  [0:ROOT_STEPS];
  logic signed [31:0] rt_ey  [0:ROOT_STEPS];
  logic               rt_neg [0:ROOT_STEPS];

  logic [31:0]        r5_s;
  logic signed [31:0] r5_da, r5_ex, r5_ey;
  logic               r5_neg;
  logic [32:0]        s_round;

  logic [31:0]        sd_s   [0:SIDE-1];
  logic signed [31:0] sd_da  [0:SIDE-1];
  logic               sd_neg [0:SIDE-1];
  angle_t             za, zb;

  logic [31:0]        mda;
  logic [48:0]        q1_rlo, q1_rhi, q1_tlo, q1_thi;
  logic signed [35:0] q1_diff;
  logic               q1_neg, q1_dneg;

  logic [66:0]        q2_pr, q2_pt;
  logic signed [35:0] q2_ph, d2;
  logic               q2_neg, q2_dneg;

  logic [66:0]        rr, rq, tr, tq;
  logic [31:0]        tmag;
  result_t            q3, out_r, skid_r;
  logic               out_v, skid_v, out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      orbit_speed <= SPEED_RESET;
    end else if (cfg_wr_en) begin
      orbit_speed <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    speed_um <= 34'(orbit_speed) * 34'd1000;
  end

  assign en       = !skid_v;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], s_tvalid};
    end
  end

  // squares of the magnitudes
  always_comb begin
    ma = r1_da[31] ? 32'(-r1_da) : 32'(r1_da);
    mx = r1_ex[31] ? 32'(-r1_ex) : 32'(r1_ex);
    my = r1_ey[31] ? 32'(-r1_ey) : 32'(r1_ey);
    pa = ma * ma;
    px = mx * mx;
    py = my * my;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_da  <= s_tdata[31:0];
      r1_ex  <= s_tdata[63:32];
      r1_ey  <= s_tdata[95:64];
      r2_sqa <= pa;
      r2_sqx <= px;
      r2_sqy <= py;
      r2_da  <= r1_da;
      r2_ex  <= r1_ex;
      r2_ey  <= r1_ey;
      r3_sum <= r2_sqx + r2_sqy;
      r3_sqa <= r2_sqa;
      r3_da  <= r2_da;
      r3_ex  <= r2_ex;
      r3_ey  <= r2_ey;
      rt_neg[0] <= (r3_sum < r3_sqa);
      rt_n[0]   <= (r3_sum < r3_sqa) ? 64'd0 : r3_sum - r3_sqa;
      rt_res[0] <= '0;
      rt_da[0]  <= r3_da;
      rt_ex[0]  <= r3_ex;
      rt_ey[0]  <= r3_ey;
    end
  end

  // digit-by-digit square root, one result bit per stage
  genvar k;
  for (k = 0; k < ROOT_STEPS; k++) begin : g_root
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    assign trial = rt_res[k] + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if (rt_n[k] >= trial) begin
          rt_n[k+1]   <= rt_n[k] - trial;
          rt_res[k+1] <= (rt_res[k] >> 1) + BIT;
        end else begin
          rt_n[k+1]   <= rt_n[k];
          rt_res[k+1] <= rt_res[k] >> 1;
        end
        rt_da[k+1]  <= rt_da[k];
        rt_ex[k+1]  <= rt_ex[k];
        rt_ey[k+1]  <= rt_ey[k];
        rt_neg[k+1] <= rt_neg[k];
      end
    end
  end

  // round the root to nearest: bump when the remainder exceeds the root
  assign s_round = 33'(rt_res[ROOT_STEPS][31:0])
                 + ((rt_n[ROOT_STEPS] > rt_res[ROOT_STEPS]) ? 33'd1 : 33'd0);

  always_ff @(posedge clk) begin
    if (en) begin
      r5_s   <= s_round[31:0];
      r5_da  <= rt_da[ROOT_STEPS];
      r5_ex  <= rt_ex[ROOT_STEPS];
      r5_ey  <= rt_ey[ROOT_STEPS];
      r5_neg <= rt_neg[ROOT_STEPS];
    end
  end

  ippi_cordic u_cordic_a (
    .clk   (clk),
    .en    (en),
    .y_in  ($signed({2'b00, r5_s})),
    .x_in  (34'(r5_da)),
    .z_out (za)
  );

  ippi_cordic u_cordic_b (
    .clk   (clk),
    .en    (en),
    .y_in  (34'(r5_ex)),
    .x_in  (34'(r5_ey)),
    .z_out (zb)
  );

  // carry root, axis difference and flag alongside the CORDIC stages
  always_ff @(posedge clk) begin
    if (en) begin
      sd_s[0]   <= r5_s;
      sd_da[0]  <= r5_da;
      sd_neg[0] <= r5_neg;
      for (int i = 1; i < SIDE; i++) begin
        sd_s[i]   <= sd_s[i-1];
        sd_da[i]  <= sd_da[i-1];
        sd_neg[i] <= sd_neg[i-1];
      end
    end
  end

  assign mda = sd_da[SIDE-1][31] ? 32'(-sd_da[SIDE-1]) : 32'(sd_da[SIDE-1]);

  // split the 34-bit speed into two 17-bit halves for the products
  always_ff @(posedge clk) begin
    if (en) begin
      q1_rlo  <= 49'(speed_um[16:0]) * 49'(sd_s[SIDE-1]);
      q1_rhi  <= 49'(speed_um[33:17]) * 49'(sd_s[SIDE-1]);
      q1_tlo  <= 49'(speed_um[16:0]) * 49'(mda);
      q1_thi  <= 49'(speed_um[33:17]) * 49'(mda);
      q1_diff <= 36'(za) - 36'(zb) + 36'sd2;
      q1_neg  <= sd_neg[SIDE-1];
      q1_dneg <= sd_da[SIDE-1][31];
    end
  end

  assign d2 = q1_diff >>> 2;

  always_ff @(posedge clk) begin
    if (en) begin
      q2_pr <= (67'(q1_rhi) << 17) + 67'(q1_rlo);
      q2_pt <= (67'(q1_thi) << 17) + 67'(q1_tlo);
      priority if (d2 > PHASE_LIMIT) begin
        q2_ph <= PHASE_LIMIT;
      end else if (d2 < -PHASE_LIMIT) begin
        q2_ph <= -PHASE_LIMIT;
      end else begin
        q2_ph <= d2;
      end
      q2_neg  <= q1_neg;
      q2_dneg <= q1_dneg;
    end
  end

  // round half up, then saturate
  always_comb begin
    rr = q2_pr + (67'd1 << (FRACTION_BITS - 1));
    rq = rr >> FRACTION_BITS;
    tr = q2_pt + (67'd1 << FRACTION_BITS);
    tq = tr >> (FRACTION_BITS + 1);
    if (q2_dneg) begin
      tmag = (tq > 67'h80000000) ? 32'h80000000 : tq[31:0];
    end else begin
      tmag = (tq > 67'h7FFFFFFF) ? 32'h7FFFFFFF : tq[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q3.dv_radial_um_s     <= (rq > 67'h7FFFFFFF) ? 31'h7FFFFFFF : rq[30:0];
      q3.dv_tangential_um_s <= q2_dneg ? 32'(-tmag) : tmag;
      q3.burn_phase         <= q2_ph[31:0];
      q3.radicand_negative  <= q2_neg;
    end
  end

  // output register plus skid register
  assign out_free = !out_v || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else begin
      priority if (skid_v) begin
        if (out_free) begin
          out_v  <= 1'b1;
          skid_v <= 1'b0;
        end
      end else if (vld[DEPTH-1]) begin
        if (out_free) begin
          out_v <= 1'b1;
        end else begin
          skid_v <= 1'b1;
        end
      end else if (out_free) begin
        out_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (skid_v) begin
      if (out_free) begin
        out_r <= skid_r;
      end
    end else if (vld[DEPTH-1]) begin
      if (out_free) begin
        out_r <= q3;
      end else begin
        skid_r <= q3;
      end
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = {1'b0, out_r.burn_phase, out_r.dv_tangential_um_s, out_r.dv_radial_um_s};
  assign m_tuser  = out_r.radicand_negative;

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the in-plane impulse planner: random stream traffic, scoreboard.
module testbench;
  import ippi_pkg::*;

  localparam int PIPE_CYCLES = 80;
  localparam logic [23:0] SPEED_MAX = 24'hFFFFFF;

  class impulse_scoreboard;
    logic [23:0] speed_mm_s;
    result_t     pending[$];
    int          checked;
    int          mismatches;
    int          neg_seen;
    longint      atan_tab[31];

    function new();
      speed_mm_s = SPEED_RESET;
      atan_tab = '{
        'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
        'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
        'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
        'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
        'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002,
        'h00000001};
      checked = 0;
      mismatches = 0;
      neg_seen = 0;
    endfunction

    // product a*b scaled down by 2^sh, rounded half up, saturated at cap
    function logic [63:0] scale_round(logic [63:0] a, logic [63:0] b, int sh,
                                      logic [63:0] cap);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      p = p + (128'd1 << (sh - 1));
      p = p >> sh;
      return (p > {64'd0, cap}) ? cap : p[63:0];
    endfunction

    function logic [63:0] root_round(logic [63:0] r);
      logic [63:0] res, bitv, n;
      res = 0;
      bitv = 64'd1 << 62;
      n = r;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      if (r - res * res > res) res = res + 1;
      return res;
    endfunction

    // vectoring arctangent, angle LSB 2^-30
    function longint arc_q30(longint y, longint x);
      longint z, dx, dy;
      logic [63:0] mx, my, mm;
      z = 0;
      mx = (x < 0) ? -x : x;
      my = (y < 0) ? -y : y;
      mm = (mx > my) ? mx : my;
      if (mm == 0) return 0;
      while (mm < (64'd1 << 59)) begin
        x = x * 2;
        y = y * 2;
        mm = mm << 1;
      end
      if (x < 0) begin
        z = (y >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
        x = -x;
        y = -y;
      end
      for (int i = 0; i < 31; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          z = z + atan_tab[i];
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - atan_tab[i];
        end
      end
      return z;
    endfunction

    function void note_input(logic [31:0] da_in, logic [31:0] ex_in, logic [31:0] ey_in);
      longint da, ex, ey, za, zb, ph;
      logic [63:0] su, mda, mex, mey, sum, da2, s, rad, tmag;
      result_t r;
      da = longint'($signed(da_in));
      ex = longint'($signed(ex_in));
      ey = longint'($signed(ey_in));
      su = 64'(speed_mm_s) * 64'd1000;
      mda = (da < 0) ? -da : da;
      mex = (ex < 0) ? -ex : ex;
      mey = (ey < 0) ? -ey : ey;
      sum = mex * mex + mey * mey;
      da2 = mda * mda;
      r.radicand_negative = (sum < da2);
      s = r.radicand_negative ? 64'd0 : root_round(sum - da2);
      rad = scale_round(su, s, FRACTION_BITS, 64'h7FFFFFFF);
      if (da < 0) begin
        tmag = scale_round(su, mda, FRACTION_BITS + 1, 64'h80000000);
        r.dv_tangential_um_s = 32'(64'd0 - tmag);
      end else begin
        tmag = scale_round(su, mda, FRACTION_BITS + 1, 64'h7FFFFFFF);
        r.dv_tangential_um_s = tmag[31:0];
      end
      za = arc_q30(longint'(s), da);
      zb = arc_q30(ex, ey);
      ph = (za - zb + 2) >>> 2;
      if (ph > longint'(PHASE_LIMIT)) ph = PHASE_LIMIT;
      if (ph < -longint'(PHASE_LIMIT)) ph = -longint'(PHASE_LIMIT);
      r.burn_phase = ph[31:0];
      r.dv_radial_um_s = rad[30:0];
      pending.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.radicand_negative) neg_seen++;
      if (got.dv_radial_um_s !== want.dv_radial_um_s ||
          got.dv_tangential_um_s !== want.dv_tangential_um_s ||
          got.burn_phase !== want.burn_phase ||
          got.radicand_negative !== want.radicand_negative) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch #%0d: radial %0d/%0d tang %0d/%0d phase %0d/%0d neg %0b/%0b",
                   checked, want.dv_radial_um_s, got.dv_radial_um_s,
                   $signed(want.dv_tangential_um_s), $signed(got.dv_tangential_um_s),
                   $signed(want.burn_phase), $signed(got.burn_phase),
                   want.radicand_negative, got.radicand_negative);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [23:0] cfg_wr_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [95:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [95:0] m_tdata;
  logic        m_tuser;

  impulse_scoreboard plan_board;
  int  items_sent;
  int  stall_left;
  bit  calm;
  bit  hold_request;

  in_plane_impulse_planner_top dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("in_plane_impulse_planner_top regression: fail");
    $finish;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // receiver: check accepted results, then choose next ready
  initial begin
    result_t got;
    m_tready = 0;
    stall_left = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        got.dv_radial_um_s = m_tdata[30:0];
        got.dv_tangential_um_s = m_tdata[62:31];
        got.burn_phase = m_tdata[94:63];
        got.radicand_negative = m_tuser;
        plan_board.check_result(got);
      end
      if (hold_request) begin
        hold_request = 0;
        stall_left = 400;
      end else if (stall_left == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 0;
      end else begin
        m_tready <= 1;
      end
    end
  end

  task automatic send_item(logic [31:0] da, logic [31:0] ex, logic [31:0] ey);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {ey, ex, da};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    plan_board.note_input(da, ex, ey);
    items_sent++;
  endtask

  // drain in-flight items, then write the orbit speed
  task automatic set_speed(logic [23:0] v);
    s_tvalid <= 0;
    @(posedge clk);
    while (plan_board.pending.size() != 0) @(posedge clk);
    repeat (PIPE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 0;
    plan_board.speed_mm_s = v;
  endtask

  function automatic logic [31:0] rand_field();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: v = 32'h80000000;
          1: v = 32'h7FFFFFFF;
          2: v = 32'h0;
          default: v = 32'hFFFFFFFF;
        endcase
      end
      default: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  task automatic directed_set();
    send_item(0, 0, 0);
    send_item(32'h80000000, 32'h80000000, 32'h80000000);
    send_item(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_item(32'h80000000, 0, 0);
    send_item(32'h7FFFFFFF, 0, 0);
    send_item(0, 32'h7FFFFFFF, 32'h80000000);
    send_item(1000, 1, 1);
    send_item(-1000, -3, 2);
    send_item(0, 5, 0);
    send_item(0, -5, 0);
    send_item(0, 0, -5);
    send_item(-1, 32'h80000000, 32'h7FFFFFFF);
  endtask

  task automatic random_run(int count);
    logic [31:0] da, ex, ey;
    for (int i = 0; i < count; i++) begin
      ex = rand_field();
      ey = rand_field();
      if ($urandom_range(0, 9) < 7) begin
        // keep the axis term under the eccentricity so the root is real
        da = 32'($signed($urandom_range(0, 1) ? ex : ey) >>> $urandom_range(1, 8));
        if ($urandom_range(0, 1)) da = -da;
      end else begin
        da = rand_field();
      end
      if (items_sent == 500) hold_request = 1;
      send_item(da, ex, ey);
    end
  endtask

  initial begin
    logic [23:0] speeds[5];
    plan_board = new();
    items_sent = 0;
    calm = 0;
    hold_request = 0;
    rst = 1;
    cfg_wr_en = 0;
    cfg_wr_data = 0;
    s_tvalid = 0;
    s_tdata = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    directed_set();
    random_run(200);
    speeds = '{24'd0, SPEED_MAX, 24'd1, 24'($urandom), SPEED_RESET};
    foreach (speeds[p]) begin
      set_speed(speeds[p]);
      directed_set();
      calm = (p == 2);
      random_run(230);
      calm = 0;
    end
    s_tvalid <= 0;
    while (plan_board.pending.size() != 0) @(posedge clk);
    repeat (PIPE_CYCLES) @(posedge clk);
    $display("%0d items over six orbit speeds, zero and full scale among them", items_sent);
    $display("%0d results compared, %0d with negative radicand, %0d mismatches",
             plan_board.checked, plan_board.neg_seen, plan_board.mismatches);
    if (plan_board.mismatches == 0)
      $display("in_plane_impulse_planner_top regression: pass");
    else
      $display("in_plane_impulse_planner_top regression: fail");
    $finish;
  end

endmodule
